>>> rtl/pc1sd_pkg.sv
package pc1sd_pkg;

    // Keystream rounds per byte and the width of the round counter.
    localparam int unsigned ROUNDS = 5;
    localparam int unsigned RND_W  = 3;

    // Key storage is kept as five 16-bit words, one per round.
    localparam int unsigned KEY_WORDS = 5;

    // Multiplier constants of the cipher.
    localparam logic [15:0] MUL_A = 16'h4e35;
    localparam logic [15:0] MUL_B = 16'h015a;

    // CRC restart value.
    localparam logic [15:0] CRC_INIT = 16'hffff;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b1;

    // Reflected CRC-16 (0x8408) table, one nibble at a time.
    localparam logic [15:0] CRC_TAB [16] = '{
        16'h0000, 16'h1081, 16'h2102, 16'h3183, 16'h4204, 16'h5285, 16'h6306, 16'h7387,
        16'h8408, 16'h9489, 16'ha50a, 16'hb58b, 16'hc60c, 16'hd68d, 16'he70e, 16'hf78f
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;   // input beat accepted
        logic             mul;    // first half of a round: products
        logic             add;    // second half of a round: sums and key word
        logic             fin;    // plaintext, key feedback, CRC, output register
        logic [RND_W-1:0] rnd;    // current round number
    } pc1sd_cmd_t;

endpackage

>>> rtl/pc1sd_in_if.sv
interface pc1sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       first;
    logic       last;

    modport source (output valid, output cipher_byte, output first, output last,
                    input ready);
    modport sink   (input valid, input cipher_byte, input first, input last,
                    output ready);
endinterface

>>> rtl/pc1sd_out_if.sv
interface pc1sd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  plain_byte;
    logic [15:0] running_crc;
    logic        end_of_sector;

    modport source (output valid, output plain_byte, output running_crc,
                    output end_of_sector, input ready);
    modport sink   (input valid, input plain_byte, input running_crc,
                    input end_of_sector, output ready);
endinterface

>>> rtl/pc1sd_cfg_if.sv
interface pc1sd_cfg_if
    import pc1sd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/pc1sd_ctrl.sv
module pc1sd_ctrl
    import pc1sd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output pc1sd_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_FIN
    } state_t;

    state_t           state_reg;
    logic [RND_W-1:0] rnd_reg;
    logic             out_valid_reg;
    logic             fin_go;

    // The result register can take a new byte when empty or being drained.
    assign fin_go = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Commands to the datapath.
    always_comb
    begin
        cmd.load = (state_reg == S_IDLE) && in_valid;
        cmd.mul  = (state_reg == S_MUL);
        cmd.add  = (state_reg == S_ADD);
        cmd.fin  = fin_go;
        cmd.rnd  = rnd_reg;
    end

    // Sequencer: accept, five rounds of multiply then add, finish.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_MUL;
                        rnd_reg   <= '0;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    if (rnd_reg == RND_W'(ROUNDS - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                        rnd_reg   <= rnd_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Output beat flag: loading wins over draining.
            priority if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/pc1sd_dp.sv
module pc1sd_dp
    import pc1sd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pc1sd_cmd_t           cmd,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic [7:0]           cipher_byte,
    input  logic                 first,
    input  logic                 last,
    output logic [7:0]           plain_byte,
    output logic [15:0]          running_crc,
    output logic                 end_of_sector
);

    // Architectural state.
    logic [15:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [15:0] key_word_reg [KEY_WORDS];
    logic [15:0] prod_carry_reg;
    logic [15:0] sum_carry_reg;
    logic [15:0] crc_reg;

    // Per-byte working registers.
    logic [7:0]  cb_reg;
    logic        last_reg;
    logic [15:0] word_reg;
    logic [15:0] acc_reg;
    logic [15:0] p1_reg;
    logic [15:0] p2_reg;
    logic [15:0] ka_reg;
    logic [7:0]  plain_reg;
    logic [15:0] crc_out_reg;
    logic        eos_reg;

    // Round logic.
    logic [15:0] kw;
    logic [15:0] k;
    logic [15:0] seed;
    logic [31:0] p1_full;
    logic [31:0] p2_full;
    logic [31:0] ka_full;
    logic [15:0] sum;
    logic [15:0] nk;

    // Finish logic.
    logic [7:0]  pb;
    logic [15:0] crc_lo;
    logic [15:0] crc_hi;

    // Multiply half of a round: pick the key word and form the three products.
    always_comb
    begin
        kw      = key_word_reg[cmd.rnd];
        k       = (cmd.rnd == '0) ? kw : (word_reg ^ kw);
        seed    = sum_carry_reg + {{(16-RND_W){1'b0}}, cmd.rnd};
        p1_full = seed * MUL_A;
        p2_full = MUL_B * k;
        ka_full = k * MUL_A;
    end

    // Add half of a round.
    assign sum = p1_reg + p2_reg + prod_carry_reg;
    assign nk  = ka_reg + 16'd1;

    // Plaintext and two CRC nibble steps, low nibble first.
    always_comb
    begin
        pb     = cb_reg ^ acc_reg[15:8] ^ acc_reg[7:0];
        crc_lo = {4'h0, crc_reg[15:4]} ^ CRC_TAB[crc_reg[3:0] ^ pb[3:0]];
        crc_hi = {4'h0, crc_lo[15:4]} ^ CRC_TAB[crc_lo[3:0] ^ pb[7:4]];
    end

    // Registers, key store, carries and CRC.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            prod_carry_reg <= '0;
            sum_carry_reg  <= '0;
            crc_reg        <= CRC_INIT;
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_word_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_HIGH: key_high_reg <= cfg_data[15:0];
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    default:      key_low_reg  <= key_low_reg;
                endcase
            end

            // A first byte restarts the key, the carries and the CRC.
            if (cmd.load && first)
            begin
                key_word_reg[0] <= key_high_reg;
                for (int i = 1; i < KEY_WORDS; i++)
                begin
                    key_word_reg[i] <= key_low_reg[79 - 16*i -: 16];
                end
                prod_carry_reg <= '0;
                sum_carry_reg  <= '0;
                crc_reg        <= CRC_INIT;
            end

            if (cmd.add)
            begin
                prod_carry_reg <= p2_reg;
                sum_carry_reg  <= sum;
            end

            // Plaintext feeds back into every key byte.
            if (cmd.fin)
            begin
                for (int i = 0; i < KEY_WORDS; i++)
                begin
                    key_word_reg[i] <= key_word_reg[i] ^ {pb, pb};
                end
                crc_reg <= crc_hi;
            end
        end
    end

    // Working registers and the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cb_reg   <= cipher_byte;
            last_reg <= last;
            acc_reg  <= '0;
        end
        if (cmd.mul)
        begin
            p1_reg <= p1_full[15:0];
            p2_reg <= p2_full[15:0];
            ka_reg <= ka_full[15:0];
        end
        if (cmd.add)
        begin
            word_reg <= nk;
            acc_reg  <= acc_reg ^ nk ^ sum;
        end
        if (cmd.fin)
        begin
            plain_reg   <= pb;
            crc_out_reg <= crc_hi;
            eos_reg     <= last_reg;
        end
    end

    assign plain_byte    = plain_reg;
    assign running_crc   = crc_out_reg;
    assign end_of_sector = eos_reg;

endmodule

>>> rtl/pc1_sector_decrypt_crc.sv
// Decrypts sector bytes with the PC1 stream cipher (80-bit key) and keeps a
// reflected CRC-16 (0x8408, init 0xFFFF) over the plaintext. Each input beat
// returns exactly one output beat with the plain byte, the CRC so far and the
// copied end-of-sector flag. A beat with first set reloads the working key
// from the key registers and restarts the carries and the CRC. A byte goes
// through an accept state, five keystream rounds on a single shared round
// unit (products, then sums), and a finish state that loads the output
// register. The next byte is taken no earlier than the cycle after the
// finish, so only one byte is in the rounds at a time. The output register
// lets the block accept the next byte while a result still waits; the
// finish cycle of that next byte holds until the waiting result has been
// taken. Key registers are written through the configuration channel,
// which is always ready, and should only be written while no byte is in
// flight.
module pc1_sector_decrypt_crc
    import pc1sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pc1sd_in_if.sink    sector_in,
    pc1sd_out_if.source sector_out,
    pc1sd_cfg_if.sink   cfg
);

    pc1sd_cmd_t cmd;

    assign cfg.ready = 1'b1;

    // Sequencer.
    pc1sd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sector_in.valid),
        .in_ready  (sector_in.ready),
        .out_valid (sector_out.valid),
        .out_ready (sector_out.ready),
        .cmd       (cmd)
    );

    // Cipher, key store and CRC.
    pc1sd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .cipher_byte   (sector_in.cipher_byte),
        .first         (sector_in.first),
        .last          (sector_in.last),
        .plain_byte    (sector_out.plain_byte),
        .running_crc   (sector_out.running_crc),
        .end_of_sector (sector_out.end_of_sector)
    );

endmodule
